FILE: rtl/shp_pkg.sv
`default_nettype none
package shp_pkg;

    localparam int CHAN_BITS    = 8;
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [CHAN_BITS-1:0] t_chan;

    typedef struct packed {
        t_chan blue;
        t_chan green;
        t_chan red;
    } t_rgb;

    typedef struct packed {
        logic drain;
        logic emit;
        logic last;
        logic up_ok;
        logic lf_ok;
        logic rt_ok;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/shp_in_if.sv
`default_nettype none
interface shp_in_if;
    import shp_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;

    modport source (output valid, op, red_in, green_in, blue_in, input ready);
    modport sink (input valid, op, red_in, green_in, blue_in, output ready);

endinterface
`default_nettype wire

FILE: rtl/shp_out_if.sv
`default_nettype none
interface shp_out_if;
    import shp_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red_out;
    t_chan green_out;
    t_chan blue_out;
    logic  row_end;
    logic  frame_end;

    modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, row_end, frame_end,
                  output ready);

endinterface
`default_nettype wire

FILE: rtl/shp_front.sv
`default_nettype none
module shp_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [shp_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire [shp_pkg::CFG_BITS-1:0]         i_cfg_data,
    shp_in_if.sink                              i_pix,
    output logic                                o_push,
    input  wire                                 i_push_ready,
    output shp_pkg::t_cmd                       o_cmd,
    output logic [COL_BITS-1:0]                 o_col,
    output shp_pkg::t_rgb                       o_px
);
    import shp_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int RB = $clog2(MAX_HEIGHT + 1);
    localparam int XB = COL_BITS + 1;

    function automatic logic [CFG_BITS-1:0] cfg_limit(input logic [CFG_BITS-1:0] v,
                                                      input int max_v);
        logic [CFG_BITS-1:0] lim;
        if (v == '0) begin
            lim = CFG_BITS'(1);
        end else if (int'(v) > max_v) begin
            lim = CFG_BITS'(max_v);
        end else begin
            lim = v;
        end
        return lim;
    endfunction

    logic [WB-1:0]       r_w_lim;
    logic [RB-1:0]       r_h_lim;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [COL_BITS-1:0] r_drain, n_drain;
    logic [RB-1:0]       r_row, n_row;
    logic                accept;
    logic                is_drain;
    logic [COL_BITS-1:0] j;
    logic                last;
    logic                n_push;
    t_cmd                n_cmd;

    assign i_pix.ready = i_push_ready;
    assign accept      = i_pix.valid && i_push_ready;
    assign is_drain    = (i_pix.op == OP_DRAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_lim <= WB'(1);
            r_h_lim <= RB'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_w_lim <= WB'(cfg_limit(i_cfg_data, MAX_WIDTH));
                end
                CFG_FRAME_HEIGHT: begin
                    r_h_lim <= RB'(cfg_limit(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        n_push  = 1'b0;
        j       = is_drain ? r_drain : r_col;
        last    = (XB'(j) + XB'(1)) >= XB'(r_w_lim);

        n_cmd.drain = is_drain;
        n_cmd.emit  = is_drain || (r_row != '0);
        n_cmd.last  = last;
        n_cmd.up_ok = r_row > RB'(1);
        n_cmd.lf_ok = j != '0;
        n_cmd.rt_ok = !last;

        if (accept) begin
            if (is_drain) begin
                if (r_row >= r_h_lim) begin
                    n_push = 1'b1;
                    if (last) begin
                        n_drain = '0;
                        n_row   = '0;
                        n_col   = '0;
                    end else begin
                        n_drain = j + COL_BITS'(1);
                    end
                end
            end else if (r_row < r_h_lim) begin
                n_push = 1'b1;
                if (last) begin
                    n_col = '0;
                    n_row = r_row + RB'(1);
                end else begin
                    n_col = j + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
        end
    end

    assign o_push    = n_push;
    assign o_cmd     = n_cmd;
    assign o_col     = j;
    assign o_px.red   = i_pix.red_in;
    assign o_px.green = i_pix.green_in;
    assign o_px.blue  = i_pix.blue_in;

endmodule
`default_nettype wire

FILE: rtl/shp_queue.sv
`default_nettype none
module shp_queue #(
    parameter int DATA_BITS = 42
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire [DATA_BITS-1:0]  i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data,
    input  wire                  i_pop
);
    import shp_pkg::*;

    localparam int AB = $clog2(QUEUE_DEPTH);

    logic [DATA_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [AB-1:0]        r_wr;
    logic [AB-1:0]        r_rd;
    logic [AB:0]          r_cnt;
    logic                 push;
    logic                 pop;

    assign o_ready = r_cnt != (AB + 1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + AB'(1);
            end
            if (pop) begin
                r_rd <= r_rd + AB'(1);
            end
            case ({push, pop})
                2'b10: begin
                    r_cnt <= r_cnt + (AB + 1)'(1);
                end
                2'b01: begin
                    r_cnt <= r_cnt - (AB + 1)'(1);
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/shp_back.sv
`default_nettype none
module shp_back #(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_pop,
    input  wire shp_pkg::t_cmd   i_cmd,
    input  wire [COL_BITS-1:0]   i_col,
    input  wire shp_pkg::t_rgb   i_px,
    shp_out_if.source            o_res
);
    import shp_pkg::*;

    localparam int ACC_BITS = CHAN_BITS + 4;

    function automatic t_chan sharp_chan(input t_chan c, input t_chan up, input t_chan dn,
                                         input t_chan lf, input t_chan rt);
        logic [ACC_BITS-1:0] acc;
        t_chan               v;
        acc = (ACC_BITS'(c) << 2) + ACC_BITS'(c) - ACC_BITS'(up) - ACC_BITS'(dn)
            - ACC_BITS'(lf) - ACC_BITS'(rt);
        if (acc[ACC_BITS-1]) begin
            v = '0;
        end else if (acc[ACC_BITS-2:CHAN_BITS] != '0) begin
            v = '1;
        end else begin
            v = acc[CHAN_BITS-1:0];
        end
        return v;
    endfunction

    t_rgb                r_prior_mem [MAX_WIDTH];
    t_rgb                r_older_mem [MAX_WIDTH];
    t_rgb                r_rd_c;
    t_rgb                r_rd_r;
    t_rgb                r_rd_u;
    logic                r_byp_c;
    logic                r_byp_r;
    t_rgb                r_byp_px;
    t_rgb                r_byp_old;
    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    logic [COL_BITS-1:0] r_s1_col;
    t_rgb                r_s1_px;
    t_rgb                r_left;
    t_rgb                r_drain_left;
    logic [COL_BITS-1:0] r_drain_col;
    logic                r_out_valid;
    t_rgb                r_out_px;
    logic                r_out_row_end;
    logic                r_out_frame_end;

    logic                advance;
    logic                s1_wr;
    logic [COL_BITS-1:0] col_next;
    t_rgb                c;
    t_rgb                rt_raw;
    t_rgb                up_raw;
    t_rgb                up;
    t_rgb                dn;
    t_rgb                lf;
    t_rgb                rt;
    t_rgb                res;

    assign advance  = !r_out_valid || o_res.ready;
    assign o_pop    = advance;
    assign s1_wr    = r_s1_valid && !r_s1_cmd.drain;
    assign col_next = i_col + COL_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (advance && s1_wr) begin
            r_prior_mem[r_s1_col] <= r_s1_px;
        end
        if (advance) begin
            r_rd_c <= r_prior_mem[i_col];
            r_rd_r <= r_prior_mem[col_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && s1_wr) begin
            r_older_mem[r_s1_col] <= c;
        end
        if (advance) begin
            r_rd_u <= r_older_mem[i_col];
        end
    end

    // forward the write of the stage ahead when it hits the address read now
    assign c      = r_byp_c ? r_byp_px  : r_rd_c;
    assign rt_raw = r_byp_r ? r_byp_px  : r_rd_r;
    assign up_raw = r_byp_c ? r_byp_old : r_rd_u;

    assign up = r_s1_cmd.up_ok ? up_raw : c;
    assign dn = r_s1_cmd.drain ? c : r_s1_px;
    assign lf = r_s1_cmd.lf_ok ? (r_s1_cmd.drain ? r_drain_left : r_left) : c;
    assign rt = r_s1_cmd.rt_ok ? rt_raw : c;

    assign res.red   = sharp_chan(c.red,   up.red,   dn.red,   lf.red,   rt.red);
    assign res.green = sharp_chan(c.green, up.green, dn.green, lf.green, rt.green);
    assign res.blue  = sharp_chan(c.blue,  up.blue,  dn.blue,  lf.blue,  rt.blue);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cmd        <= i_cmd;
            r_s1_col        <= i_col;
            r_s1_px         <= i_px;
            r_byp_c         <= s1_wr && (r_s1_col == i_col);
            r_byp_r         <= s1_wr && (r_s1_col == col_next);
            r_byp_px        <= r_s1_px;
            r_byp_old       <= c;
            r_out_px        <= res;
            r_out_row_end   <= r_s1_cmd.last;
            r_out_frame_end <= r_s1_cmd.drain && r_s1_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_left       <= '0;
            r_drain_left <= '0;
            r_drain_col  <= '0;
        end else if (advance) begin
            r_s1_valid  <= i_valid;
            r_out_valid <= r_s1_valid && r_s1_cmd.emit;
            if (s1_wr) begin
                r_left <= c;
            end
            // track the prior-row entry left of the next drain column
            if (r_s1_valid && r_s1_cmd.drain) begin
                r_drain_left <= c;
                r_drain_col  <= r_s1_col;
            end else if (s1_wr && (r_s1_col == r_drain_col)) begin
                r_drain_left <= r_s1_px;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.red_out   = r_out_px.red;
    assign o_res.green_out = r_out_px.green;
    assign o_res.blue_out  = r_out_px.blue;
    assign o_res.row_end   = r_out_row_end;
    assign o_res.frame_end = r_out_frame_end;

endmodule
`default_nettype wire

FILE: rtl/sharpen_3x3_rgb_stream_core.sv
`default_nettype none
// 3x3 Laplacian sharpen (5 x centre minus up, down, left, right, saturated) on an RGB
// raster stream with edge replication. Sustains one word per clock on both sides while
// neither side stalls; a word's result passes through the queue, the line-store read
// stage and the output register, and the queue and output register let the two sides
// stall on their own. The result for row i-1 column j is computed once pixel (i,j) is
// taken; row 0 pixels give nothing. After the frame, send frame_width drain words to
// flush the last row; pixels past the frame and drains before it is complete are
// taken and dropped. Two line stores of MAX_WIDTH x 24 bits hold the two previous
// rows; the prior-row store is read at two addresses and written once per clock. The
// stores need no clearing after reset. Write frame_width and frame_height only while
// the block is idle.
module sharpen_3x3_rgb_stream_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [shp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire [shp_pkg::CFG_BITS-1:0]      i_cfg_data,
    shp_in_if.sink                           i_pix,
    shp_out_if.source                        o_res
);
    import shp_pkg::*;

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Q_BITS   = $bits(t_cmd) + COL_BITS + $bits(t_rgb);

    logic                q_push;
    logic                q_ready;
    logic                q_valid;
    logic                q_pop;
    logic [Q_BITS-1:0]   q_din;
    logic [Q_BITS-1:0]   q_dout;
    t_cmd                f_cmd;
    logic [COL_BITS-1:0] f_col;
    t_rgb                f_px;
    t_cmd                b_cmd;
    logic [COL_BITS-1:0] b_col;
    t_rgb                b_px;

    shp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pix        (i_pix),
        .o_push       (q_push),
        .i_push_ready (q_ready),
        .o_cmd        (f_cmd),
        .o_col        (f_col),
        .o_px         (f_px)
    );

    assign q_din = {f_cmd, f_col, f_px};

    shp_queue #(
        .DATA_BITS (Q_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_dout),
        .i_pop   (q_pop)
    );

    assign {b_cmd, b_col, b_px} = q_dout;

    shp_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_cmd   (b_cmd),
        .i_col   (b_col),
        .i_px    (b_px),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (i_pix.valid && i_pix.ready))
        else $error("queue push without an accepted word");

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_end) |-> o_res.row_end)
        else $error("frame end on a word that does not close its row");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_ready |-> !i_pix.ready)
        else $error("input ready while the queue is full");
`endif

endmodule
`default_nettype wire
